>>> design/dvsd_pkg.sv
// shared types and constants for the delta varint span decoder
`timescale 1ns / 1ps

package dvsd_pkg;

  // widths fixed by the stream format and the result ports
  localparam int unsigned IdPortW    = 48;
  localparam int unsigned CoordW     = 32;
  localparam int unsigned VarintW    = 64;
  localparam int unsigned VarintCntW = 4;
  // byte count at which the varint shift stops growing (shift of 70)
  localparam int unsigned VarintSatCnt = 10;

  typedef enum logic [2:0] {
    PhHeader,
    PhFixX,
    PhFixY,
    PhDx,
    PhDy,
    PhDone
  } phase_e;

  typedef struct packed {
    logic feed;     // accepted byte belongs to a varint
    logic restart;  // walk restarts: collector starts from empty
  } vint_ctl_t;

  typedef struct packed {
    logic [IdPortW-1:0] node_id;
    logic [CoordW-1:0]  x_coord;
    logic [CoordW-1:0]  y_coord;
    logic               is_match;
    logic               end_of_block;
  } result_t;

endpackage

>>> design/delta_varint_span_decoder_core.sv
// top level of the delta varint span decoder
`timescale 1ns / 1ps

// usage:
//  - input channel (in_valid_i / in_ready_o) carries one byte of an encoded
//    block per transaction; first_byte_i = 1 starts a walk and loads
//    start_id_i and target_id_i, its data byte is the first header byte
//  - output channel (out_valid_o / out_ready_i) carries one transaction per
//    decoded node (id, x, y, match flag) and one for the end-of-block marker
//  - a byte is decoded in the cycle it is accepted: header varints, fixed
//    coordinates and zigzag deltas all resolve in one pass of logic, so the
//    block takes one byte per cycle while in_ready_o stays high
//  - a result is registered before it shows on the output
//  - the output side is a result register plus one skid entry; in_ready_o
//    drops only while the skid entry is occupied, i.e. after the receiver
//    has stalled with a result already waiting
//  - reset empties both output entries and puts the decoder in the header
//    phase with id, target and coordinates at zero
//  - ids wrap modulo 2^ID_BITS; node_id_o shows the low 48 bits
//  - after the end marker bytes are dropped until first_byte_i comes back

module delta_varint_span_decoder_core #(
  parameter int unsigned ID_BITS = 48
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [7:0]                        data_byte_i,
  input  logic                              first_byte_i,
  input  logic [dvsd_pkg::IdPortW-1:0]      start_id_i,
  input  logic [dvsd_pkg::IdPortW-1:0]      target_id_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [dvsd_pkg::IdPortW-1:0]      node_id_o,
  output logic [dvsd_pkg::CoordW-1:0]       x_coord_o,
  output logic [dvsd_pkg::CoordW-1:0]       y_coord_o,
  output logic                              is_match_o,
  output logic                              end_of_block_o
);

  localparam int unsigned CntW = dvsd_pkg::VarintW - 1;

  // decoder state
  dvsd_pkg::phase_e                 phase_q, phase_d, phase_eff;
  logic [ID_BITS-1:0]               cur_q, cur_d, cur_eff;
  logic [ID_BITS-1:0]               tgt_q, tgt_eff;
  logic [CntW-1:0]                  left_q, left_d, left_eff, left_dec;
  logic [1:0]                       fcnt_q, fcnt_d, fcnt_eff;
  logic [dvsd_pkg::CoordW-1:0]      x_q, x_d, y_q, y_d;

  logic                             in_fire;
  logic                             buf_full;
  dvsd_pkg::vint_ctl_t              vint_ctl;
  logic                             vint_done;
  logic [dvsd_pkg::VarintW-1:0]     vint_value;
  logic [dvsd_pkg::CoordW-1:0]      delta;
  logic [dvsd_pkg::CoordW-1:0]      fix_byte;
  logic [dvsd_pkg::VarintW-1:0]     cur_wide;
  logic [dvsd_pkg::VarintW-1:0]     start_wide, target_wide;
  logic                             res_valid;
  dvsd_pkg::result_t                res;
  dvsd_pkg::result_t                out_data;

  assign in_ready_o = !buf_full;
  assign in_fire    = in_valid_i && in_ready_o;

  // a walk start overrides the stored state for this byte
  assign start_wide  = dvsd_pkg::VarintW'(start_id_i);
  assign target_wide = dvsd_pkg::VarintW'(target_id_i);
  assign phase_eff   = first_byte_i ? dvsd_pkg::PhHeader : phase_q;
  assign cur_eff     = first_byte_i ? start_wide[ID_BITS-1:0] : cur_q;
  assign tgt_eff     = first_byte_i ? target_wide[ID_BITS-1:0] : tgt_q;
  assign left_eff    = first_byte_i ? '0 : left_q;
  assign fcnt_eff    = first_byte_i ? '0 : fcnt_q;
  assign left_dec    = left_eff - 1'b1;
  assign cur_wide    = dvsd_pkg::VarintW'(cur_eff);

  // zigzag decode of the low 33 bits of the collected varint
  assign delta    = vint_value[dvsd_pkg::CoordW:1] ^ {dvsd_pkg::CoordW{vint_value[0]}};
  assign fix_byte = dvsd_pkg::CoordW'(data_byte_i) << {fcnt_eff, 3'b000};

  always_comb begin
    vint_ctl.restart = in_fire && first_byte_i;
    vint_ctl.feed    = 1'b0;
    if (in_fire) begin
      case (phase_eff) inside
        dvsd_pkg::PhHeader, dvsd_pkg::PhDx, dvsd_pkg::PhDy: vint_ctl.feed = 1'b1;
        default:                                            vint_ctl.feed = 1'b0;
      endcase
    end
  end

  dvsd_varint u_varint (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (vint_ctl),
    .data_byte_i (data_byte_i),
    .done_o      (vint_done),
    .value_o     (vint_value)
  );

  // next phase
  always_comb begin
    phase_d = phase_eff;
    unique case (phase_eff)
      dvsd_pkg::PhHeader: begin
        if (vint_done) begin
          if (!vint_value[0]) begin
            phase_d = dvsd_pkg::PhFixX;
          end else if (vint_value[dvsd_pkg::VarintW-1:1] == '0) begin
            phase_d = dvsd_pkg::PhDone;
          end
        end
      end
      dvsd_pkg::PhFixX: begin
        if (fcnt_eff == 2'd3) phase_d = dvsd_pkg::PhFixY;
      end
      dvsd_pkg::PhFixY: begin
        if (fcnt_eff == 2'd3) begin
          phase_d = (left_eff == '0) ? dvsd_pkg::PhHeader : dvsd_pkg::PhDx;
        end
      end
      dvsd_pkg::PhDx: begin
        if (vint_done) phase_d = dvsd_pkg::PhDy;
      end
      dvsd_pkg::PhDy: begin
        if (vint_done) begin
          phase_d = (left_dec == '0) ? dvsd_pkg::PhHeader : dvsd_pkg::PhDx;
        end
      end
      dvsd_pkg::PhDone: phase_d = dvsd_pkg::PhDone;
      default:          phase_d = dvsd_pkg::PhHeader;
    endcase
  end

  // datapath and result
  always_comb begin
    cur_d            = cur_eff;
    left_d           = left_eff;
    fcnt_d           = fcnt_eff;
    x_d              = x_q;
    y_d              = y_q;
    res_valid        = 1'b0;
    res.node_id      = cur_wide[dvsd_pkg::IdPortW-1:0];
    res.x_coord      = x_q;
    res.y_coord      = y_q;
    res.is_match     = (cur_eff == tgt_eff);
    res.end_of_block = 1'b0;
    unique case (phase_eff)
      dvsd_pkg::PhHeader: begin
        if (vint_done) begin
          if (vint_value[0]) begin
            if (vint_value[dvsd_pkg::VarintW-1:1] != '0) begin
              // skip span: advance id
              cur_d = cur_eff + vint_value[ID_BITS:1];
            end else begin
              // end marker
              res_valid        = 1'b1;
              res.x_coord      = '0;
              res.y_coord      = '0;
              res.is_match     = 1'b0;
              res.end_of_block = 1'b1;
            end
          end else begin
            left_d = vint_value[dvsd_pkg::VarintW-1:1];
            fcnt_d = '0;
            x_d    = '0;
            y_d    = '0;
          end
        end
      end
      dvsd_pkg::PhFixX: begin
        x_d    = x_q | fix_byte;
        fcnt_d = fcnt_eff + 1'b1;
      end
      dvsd_pkg::PhFixY: begin
        y_d    = y_q | fix_byte;
        fcnt_d = fcnt_eff + 1'b1;
        if (fcnt_eff == 2'd3) begin
          res_valid   = 1'b1;
          res.y_coord = y_d;
          cur_d       = cur_eff + 1'b1;
        end
      end
      dvsd_pkg::PhDx: begin
        if (vint_done) x_d = x_q + delta;
      end
      dvsd_pkg::PhDy: begin
        if (vint_done) begin
          y_d         = y_q + delta;
          res_valid   = 1'b1;
          res.y_coord = y_d;
          cur_d       = cur_eff + 1'b1;
          left_d      = left_dec;
        end
      end
      dvsd_pkg::PhDone: res_valid = 1'b0;
      default:          res_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dvsd_pkg::PhHeader;
      cur_q   <= '0;
      tgt_q   <= '0;
      left_q  <= '0;
      fcnt_q  <= '0;
      x_q     <= '0;
      y_q     <= '0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      cur_q   <= cur_d;
      tgt_q   <= tgt_eff;
      left_q  <= left_d;
      fcnt_q  <= fcnt_d;
      x_q     <= x_d;
      y_q     <= y_d;
    end
  end

  // result register and skid entry
  dvsd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_fire && res_valid),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign node_id_o      = out_data.node_id;
  assign x_coord_o      = out_data.x_coord;
  assign y_coord_o      = out_data.y_coord;
  assign is_match_o     = out_data.is_match;
  assign end_of_block_o = out_data.end_of_block;

endmodule

>>> design/dvsd_varint.sv
// little-endian base-128 varint collector, one byte per transaction
`timescale 1ns / 1ps

module dvsd_varint (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  dvsd_pkg::vint_ctl_t                ctl_i,
  input  logic [7:0]                         data_byte_i,
  output logic                               done_o,
  output logic [dvsd_pkg::VarintW-1:0]       value_o
);

  logic [dvsd_pkg::VarintW-1:0]    acc_q, acc_d, acc_eff;
  logic [dvsd_pkg::VarintCntW-1:0] cnt_q, cnt_d, cnt_eff;
  logic [6:0]                      shamt;
  logic [dvsd_pkg::VarintW-1:0]    payload;

  always_comb begin
    acc_eff = ctl_i.restart ? '0 : acc_q;
    cnt_eff = ctl_i.restart ? '0 : cnt_q;
    shamt   = 7'(cnt_eff) * 7'd7;
    payload = '0;
    // bits at position 64 and up fall off the top
    if (cnt_eff < dvsd_pkg::VarintCntW'(dvsd_pkg::VarintSatCnt)) begin
      payload = dvsd_pkg::VarintW'(data_byte_i[6:0]) << shamt;
    end
    value_o = acc_eff | payload;
    done_o  = !data_byte_i[7];
  end

  always_comb begin
    acc_d = acc_eff;
    cnt_d = cnt_eff;
    if (ctl_i.feed) begin
      if (done_o) begin
        acc_d = '0;
        cnt_d = '0;
      end else begin
        acc_d = value_o;
        if (cnt_eff < dvsd_pkg::VarintCntW'(dvsd_pkg::VarintSatCnt)) begin
          cnt_d = cnt_eff + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else if (ctl_i.feed || ctl_i.restart) begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> design/dvsd_out_buf.sv
// result register with a skid entry behind it
`timescale 1ns / 1ps

module dvsd_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  dvsd_pkg::result_t   push_data_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dvsd_pkg::result_t   out_data_o
);

  logic              out_v_q, skid_v_q;
  dvsd_pkg::result_t out_q, skid_q;
  logic              slot_free;

  assign slot_free   = !out_v_q || out_ready_i;
  assign full_o      = skid_v_q;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (slot_free) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= push_i;
      end
    end else if (push_i) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free) begin
      if (skid_v_q) begin
        out_q <= skid_q;
      end else if (push_i) begin
        out_q <= push_data_i;
      end
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

endmodule
